@@ rtl/lfs_pkg.sv @@
package lfs_pkg;

	// Field widths.
	localparam int SPEED_W = 15;
	localparam int RATE_W  = 16;
	localparam int TGT_W   = 16;
	localparam int DAMP_W  = 11;
	localparam int MAG_W   = 16;
	localparam int DIFF_W  = 17;
	localparam int PROD_W  = 30;

	// Fixed-point constants (Q8.8 unless noted; DAMP_MUL is scaled by 2^DAMP_SHIFT).
	localparam logic [SPEED_W-1:0] EDGE_FLOOR = 15'd512;
	localparam logic [SPEED_W-1:0] FINE_FLOOR = 15'd205;
	localparam logic [DAMP_W-1:0]  DAMP_MAX   = 11'd1024;
	localparam logic [13:0]        DAMP_MUL   = 14'd13107;
	localparam int                 DAMP_SHIFT = 14;
	localparam logic signed [DIFF_W-1:0] INNER_MIN = -17'sd11520;

	// Register reset values.
	localparam logic [RATE_W-1:0]  GYRO_BIAS_RST      = 16'd0;
	localparam logic [SPEED_W-1:0] SPEED_STRAIGHT_RST = 15'd8960;
	localparam logic [SPEED_W-1:0] SPEED_FINE_RST     = 15'd7680;
	localparam logic [SPEED_W-1:0] SPEED_STRONG_RST   = 15'd6400;
	localparam logic [SPEED_W-1:0] SPEED_SEARCH_RST   = 15'd5120;
	localparam logic [SPEED_W-1:0] STEER_FINE_RST     = 15'd3584;
	localparam logic [SPEED_W-1:0] STEER_STRONG_RST   = 15'd6400;
	localparam logic [SPEED_W-1:0] STEER_SEARCH_RST   = 15'd10240;

	typedef enum logic [2:0] {
		CFG_GYRO_BIAS      = 3'd0,
		CFG_SPEED_STRAIGHT = 3'd1,
		CFG_SPEED_FINE     = 3'd2,
		CFG_SPEED_STRONG   = 3'd3,
		CFG_SPEED_SEARCH   = 3'd4,
		CFG_STEER_FINE     = 3'd5,
		CFG_STEER_STRONG   = 3'd6,
		CFG_STEER_SEARCH   = 3'd7
	} cfg_index_t;

	typedef enum logic [3:0] {
		MODE_LOST   = 4'd0,
		MODE_EDGE_L = 4'd1,
		MODE_HARD_L = 4'd2,
		MODE_FINE_L = 4'd3,
		MODE_EDGE_R = 4'd4,
		MODE_HARD_R = 4'd5,
		MODE_FINE_R = 4'd6,
		MODE_BLACK  = 4'd7,
		MODE_CENTER = 4'd8,
		MODE_BAL    = 4'd9
	} mode_t;

	typedef struct packed {
		logic [RATE_W-1:0]  gyro_bias;
		logic [SPEED_W-1:0] speed_straight;
		logic [SPEED_W-1:0] speed_fine;
		logic [SPEED_W-1:0] speed_strong;
		logic [SPEED_W-1:0] speed_search;
		logic [SPEED_W-1:0] steer_fine;
		logic [SPEED_W-1:0] steer_strong;
		logic [SPEED_W-1:0] steer_search;
	} cfg_t;

	typedef struct packed {
		logic left_edge;
		logic left_near;
		logic center_bit;
		logic right_near;
		logic right_edge;
		logic line_lost;
		logic line_dark;
	} sensors_t;

	typedef struct packed {
		logic [SPEED_W-1:0] base;
		logic [SPEED_W-1:0] steer;
		logic               turn_left;
		logic               turn_right;
		logic               edge_any;
		mode_t              mode;
		logic [1:0]         score_left;
		logic [1:0]         score_right;
	} decision_t;

endpackage

@@ rtl/lfs_decide.sv @@
module lfs_decide
	import lfs_pkg::*;
(
	input  sensors_t  sensors,
	input  cfg_t      cfg,
	output decision_t dec
);

	logic [1:0] ls;
	logic [1:0] rs;

	assign ls = {sensors.left_edge, sensors.left_near};
	assign rs = {sensors.right_edge, sensors.right_near};

	// Pick the turn side, base speed, steer strength and mode from the line bits.
	always_comb begin
		dec             = '0;
		dec.score_left  = ls;
		dec.score_right = rs;
		dec.edge_any    = sensors.left_edge | sensors.right_edge;
		dec.mode        = MODE_LOST;
		if (sensors.line_lost) begin
			dec.base = '0;
			dec.mode = MODE_LOST;
		end else if (ls != rs) begin
			dec.turn_left  = (ls > rs);
			dec.turn_right = !(ls > rs);
			if ((ls > rs) ? sensors.left_edge : sensors.right_edge) begin
				dec.base  = sensors.center_bit ? cfg.speed_strong : cfg.speed_search;
				dec.steer = sensors.center_bit ? cfg.steer_strong : cfg.steer_search;
				if (ls > rs) begin
					dec.mode = sensors.center_bit ? MODE_EDGE_L : MODE_HARD_L;
				end else begin
					dec.mode = sensors.center_bit ? MODE_EDGE_R : MODE_HARD_R;
				end
			end else begin
				dec.base  = cfg.speed_fine;
				dec.steer = cfg.steer_fine;
				dec.mode  = (ls > rs) ? MODE_FINE_L : MODE_FINE_R;
			end
		end else if (sensors.center_bit || sensors.line_dark) begin
			dec.base = cfg.speed_straight;
			dec.mode = sensors.line_dark ? MODE_BLACK : MODE_CENTER;
		end else begin
			dec.base = cfg.speed_fine;
			dec.mode = MODE_BAL;
		end
	end

endmodule

@@ rtl/line_follow_steering.sv @@
// Four-stage pipeline: decision and gyro magnitude, damping multiply,
// steer clamp, inner wheel clamp into the output register.
// Throughput: one transaction per cycle; each stage holds its item while the
// next one is full, so a stall only backs up as far as the first empty stage.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults.
module line_follow_steering
	import lfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: left_edge[0], left_near[1], center_bit[2], right_near[3],
	// right_edge[4], line_lost[5], line_dark[6], yaw_rate[22:7], zero[23]
	input  logic [23:0] s_tdata,
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: left_target[15:0], right_target[31:16], mode_code[35:32],
	// score_left[37:36], score_right[39:38]
	output logic [39:0] m_tdata
);

	cfg_t      cfg_q;
	sensors_t  sensors;
	decision_t dec;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;

	decision_t            dec_s1, dec_s2, dec_s3;
	logic [MAG_W-1:0]     mag_s1;
	logic [DAMP_W-1:0]    damp_s2;
	logic [SPEED_W-1:0]   steer_s3;
	logic signed [TGT_W-1:0] lt_s4, rt_s4;
	mode_t                mode_s4;
	logic [1:0]           ls_s4, rs_s4;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_bias      <= GYRO_BIAS_RST;
			cfg_q.speed_straight <= SPEED_STRAIGHT_RST;
			cfg_q.speed_fine     <= SPEED_FINE_RST;
			cfg_q.speed_strong   <= SPEED_STRONG_RST;
			cfg_q.speed_search   <= SPEED_SEARCH_RST;
			cfg_q.steer_fine     <= STEER_FINE_RST;
			cfg_q.steer_strong   <= STEER_STRONG_RST;
			cfg_q.steer_search   <= STEER_SEARCH_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_GYRO_BIAS:      cfg_q.gyro_bias      <= cfg_data;
				CFG_SPEED_STRAIGHT: cfg_q.speed_straight <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_FINE:     cfg_q.speed_fine     <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_STRONG:   cfg_q.speed_strong   <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_SEARCH:   cfg_q.speed_search   <= cfg_data[SPEED_W-1:0];
				CFG_STEER_FINE:     cfg_q.steer_fine     <= cfg_data[SPEED_W-1:0];
				CFG_STEER_STRONG:   cfg_q.steer_strong   <= cfg_data[SPEED_W-1:0];
				CFG_STEER_SEARCH:   cfg_q.steer_search   <= cfg_data[SPEED_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// A stage takes a new item when it is empty or its item moves on.
	assign en4      = !v4_s4 || m_tready;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_tvalid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	// Stage 1: sensor decision and saturated gyro magnitude.
	assign sensors.left_edge  = s_tdata[0];
	assign sensors.left_near  = s_tdata[1];
	assign sensors.center_bit = s_tdata[2];
	assign sensors.right_near = s_tdata[3];
	assign sensors.right_edge = s_tdata[4];
	assign sensors.line_lost  = s_tdata[5];
	assign sensors.line_dark  = s_tdata[6];

	lfs_decide u_decide (
		.sensors (sensors),
		.cfg     (cfg_q),
		.dec     (dec)
	);

	logic [MAG_W-1:0] mag_next;

	always_comb begin
		logic signed [DIFF_W-1:0] diff;
		logic signed [DIFF_W-1:0] sat;
		logic signed [DIFF_W-1:0] absval;
		diff = $signed({s_tdata[22], s_tdata[22:7]})
			- $signed({cfg_q.gyro_bias[RATE_W-1], cfg_q.gyro_bias});
		if (diff > 17'sd32767) begin
			sat = 17'sd32767;
		end else if (diff < -17'sd32768) begin
			sat = -17'sd32768;
		end else begin
			sat = diff;
		end
		absval = (sat < 0) ? -sat : sat;
		mag_next = absval[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dec_s1 <= dec;
			mag_s1 <= mag_next;
		end
	end

	// Stage 2: damping term, |rate| * 0.8 capped at 4.0.
	logic [PROD_W-1:0] prod;
	logic [MAG_W-1:0]  damp_raw;

	assign prod     = PROD_W'(mag_s1) * PROD_W'(DAMP_MUL);
	assign damp_raw = prod[DAMP_SHIFT +: MAG_W];

	always_ff @(posedge clk) begin
		if (en2) begin
			dec_s2  <= dec_s1;
			damp_s2 <= (damp_raw > MAG_W'(DAMP_MAX)) ? DAMP_MAX : damp_raw[DAMP_W-1:0];
		end
	end

	// Stage 3: damped steer, floored and capped with the lower bound tested first; a zero steer stays zero.
	logic [SPEED_W-1:0] steer_next;

	always_comb begin
		logic signed [DIFF_W-1:0] sd;
		logic [SPEED_W-1:0]       lo;
		logic [SPEED_W-1:0]       hi;
		sd = $signed({2'b00, dec_s2.steer}) - $signed({6'd0, damp_s2});
		lo = dec_s2.edge_any ? EDGE_FLOOR : FINE_FLOOR;
		hi = dec_s2.edge_any ? cfg_q.steer_search : cfg_q.steer_fine;
		if (dec_s2.steer == '0) begin
			steer_next = '0;
		end else if (sd < $signed({2'b00, lo})) begin
			steer_next = lo;
		end else if (sd > $signed({2'b00, hi})) begin
			steer_next = hi;
		end else begin
			steer_next = sd[SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			dec_s3   <= dec_s2;
			steer_s3 <= steer_next;
		end
	end

	// Stage 4: inner wheel target, clamped to [-45.0, straight speed].
	logic signed [TGT_W-1:0] base_val;
	logic signed [TGT_W-1:0] inner_val;

	assign base_val = $signed({1'b0, dec_s3.base});

	always_comb begin
		logic signed [DIFF_W-1:0] inner;
		logic signed [DIFF_W-1:0] top;
		inner = $signed({2'b00, dec_s3.base}) - $signed({2'b00, steer_s3});
		top   = $signed({2'b00, cfg_q.speed_straight});
		if (inner < INNER_MIN) begin
			inner_val = INNER_MIN[TGT_W-1:0];
		end else if (inner > top) begin
			inner_val = top[TGT_W-1:0];
		end else begin
			inner_val = inner[TGT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			lt_s4   <= dec_s3.turn_right ? inner_val : base_val;
			rt_s4   <= dec_s3.turn_left ? inner_val : base_val;
			mode_s4 <= dec_s3.mode;
			ls_s4   <= dec_s3.score_left;
			rs_s4   <= dec_s3.score_right;
		end
	end

	assign m_tvalid = v4_s4;
	assign m_tdata  = {rs_s4, ls_s4, mode_s4, rt_s4, lt_s4};

`ifndef SYNTH
	// Back-pressure reaches the input only when every stage is full.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v1_s1 && v2_s2 && v3_s3 && v4_s4))
		else $error("input stalled with an empty pipeline stage");

	// The damping term never exceeds its cap.
	a_damp_cap: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 |-> (damp_s2 <= DAMP_MAX))
		else $error("damping term above cap");

	// Line lost drives both wheels to zero.
	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && mode_s4 == MODE_LOST) |-> (lt_s4 == '0 && rt_s4 == '0))
		else $error("lost mode with nonzero targets");

	// Modes without a turn drive both wheels alike.
	a_no_turn_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (mode_s4 == MODE_BLACK || mode_s4 == MODE_CENTER
			|| mode_s4 == MODE_BAL)) |-> (lt_s4 == rt_s4))
		else $error("straight mode with unequal targets");
`endif

endmodule

@@ bench/line_follow_steering_tb.sv @@
`timescale 1ns / 1ps

module line_follow_steering_tb;
	import lfs_pkg::*;

	// Expected output transaction, one per accepted sensor sample.
	typedef struct {
		logic [15:0] left_target;
		logic [15:0] right_target;
		mode_t       mode_code;
		logic [1:0]  score_left;
		logic [1:0]  score_right;
	} wheel_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// Shadow copy of the steering registers, used by the predictor.
	cfg_t        steer_cfg;
	wheel_cmd_t  pending_cmds[$];
	int          mismatch_count = 0;

	// Idle controls shared between the sender, the receiver and the tests.
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	bit          hold_req = 1'b0;
	int          hold_len = 0;

	line_follow_steering dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int clamp_low_first(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Computes the wheel command for one sensor sample under the current registers.
	function automatic wheel_cmd_t predict_wheel_targets(sensors_t sn, logic signed [15:0] gyro);
		wheel_cmd_t cmd;
		int bias, rate, mag, damp, base, steer, lt, rt, ls, rs, dir;
		bit turn_left, edge_hit;
		mode_t mode;
		bias = $signed(steer_cfg.gyro_bias);
		rate = int'(gyro) - bias;
		if (rate > 32767) rate = 32767;
		if (rate < -32768) rate = -32768;
		ls = (sn.left_edge ? 2 : 0) + (sn.left_near ? 1 : 0);
		rs = (sn.right_edge ? 2 : 0) + (sn.right_near ? 1 : 0);
		steer = 0;
		dir = 0;

		// Pick base speed, steer strength and mode.
		if (sn.line_lost) begin
			base = 0;
			mode = MODE_LOST;
		end else if (ls != rs) begin
			turn_left = ls > rs;
			edge_hit = turn_left ? sn.left_edge : sn.right_edge;
			dir = turn_left ? -1 : 1;
			if (edge_hit && sn.center_bit) begin
				base = steer_cfg.speed_strong;
				steer = steer_cfg.steer_strong;
				mode = turn_left ? MODE_EDGE_L : MODE_EDGE_R;
			end else if (edge_hit) begin
				base = steer_cfg.speed_search;
				steer = steer_cfg.steer_search;
				mode = turn_left ? MODE_HARD_L : MODE_HARD_R;
			end else begin
				base = steer_cfg.speed_fine;
				steer = steer_cfg.steer_fine;
				mode = turn_left ? MODE_FINE_L : MODE_FINE_R;
			end
		end else if (sn.center_bit || sn.line_dark) begin
			base = steer_cfg.speed_straight;
			mode = sn.line_dark ? MODE_BLACK : MODE_CENTER;
		end else begin
			base = steer_cfg.speed_fine;
			mode = MODE_BAL;
		end

		// Gyro damping, then the floor and cap of the steer amount.
		if (steer > 0) begin
			mag = (rate < 0) ? -rate : rate;
			damp = (mag * 13107) >> 14;
			if (damp > 1024) damp = 1024;
			if (sn.left_edge || sn.right_edge)
				steer = clamp_low_first(steer - damp, 512, steer_cfg.steer_search);
			else
				steer = clamp_low_first(steer - damp, 205, steer_cfg.steer_fine);
		end

		// Only the inner wheel is slowed.
		lt = base;
		rt = base;
		if (dir < 0)
			rt = clamp_low_first(base - steer, -11520, steer_cfg.speed_straight);
		else if (dir > 0)
			lt = clamp_low_first(base - steer, -11520, steer_cfg.speed_straight);

		cmd.left_target = 16'(lt);
		cmd.right_target = 16'(rt);
		cmd.mode_code = mode;
		cmd.score_left = 2'(ls);
		cmd.score_right = 2'(rs);
		return cmd;
	endfunction

	// Receiver: random stalls, and a long hold-off when a test asks for one.
	initial begin : sink
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 6);
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each output transaction is compared against the oldest pending command.
	always @(posedge clk) begin
		wheel_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$error("unexpected output transaction, data %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_cmds.pop_front();
				if (m_tdata[15:0] !== want.left_target) begin
					$error("left_target: expected %0d, got %0d",
						$signed(want.left_target), $signed(m_tdata[15:0]));
					mismatch_count++;
				end
				if (m_tdata[31:16] !== want.right_target) begin
					$error("right_target: expected %0d, got %0d",
						$signed(want.right_target), $signed(m_tdata[31:16]));
					mismatch_count++;
				end
				if (m_tdata[35:32] !== want.mode_code) begin
					$error("mode_code: expected %0d, got %0d", want.mode_code, m_tdata[35:32]);
					mismatch_count++;
				end
				if (m_tdata[37:36] !== want.score_left) begin
					$error("score_left: expected %0d, got %0d", want.score_left, m_tdata[37:36]);
					mismatch_count++;
				end
				if (m_tdata[39:38] !== want.score_right) begin
					$error("score_right: expected %0d, got %0d", want.score_right,
						m_tdata[39:38]);
					mismatch_count++;
				end
			end
		end
	end

	// Offers one sample and returns right after the edge that accepts it.
	task automatic send_sample(sensors_t sn, logic signed [15:0] gyro);
		int gap;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, gyro, sn.line_dark, sn.line_lost, sn.right_edge, sn.right_near,
			sn.center_bit, sn.left_near, sn.left_edge};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_cmds.push_back(predict_wheel_targets(sn, gyro));
	endtask

	function automatic sensors_t make_sensors(bit le, bit ln, bit ce, bit rn, bit re,
			bit aw, bit ab);
		sensors_t sn;
		sn.left_edge = le;
		sn.left_near = ln;
		sn.center_bit = ce;
		sn.right_near = rn;
		sn.right_edge = re;
		sn.line_lost = aw;
		sn.line_dark = ab;
		return sn;
	endfunction

	// Line bits are uniform; lost and all-black flags are kept fairly rare.
	function automatic sensors_t random_sensors();
		sensors_t sn;
		sn = 7'($urandom);
		sn.line_lost = ($urandom_range(0, 7) == 0);
		sn.line_dark = ($urandom_range(0, 5) == 0);
		return sn;
	endfunction

	// Full-range rates half the time, else rates where damping is not yet capped, or extremes.
	function automatic logic [15:0] random_rate();
		case ($urandom_range(0, 3))
			0: return 16'($signed($urandom_range(0, 1600)) - 800);
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_samples(int count);
		repeat (count) send_sample(random_sensors(), random_rate());
	endtask

	// Lowers valid and waits until every pending command has been checked.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cmds.size() != 0) @(posedge clk);
	endtask

	// Register write; only called while the pipeline is empty.
	task automatic write_register(cfg_index_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_GYRO_BIAS:      steer_cfg.gyro_bias = value;
			CFG_SPEED_STRAIGHT: steer_cfg.speed_straight = value[14:0];
			CFG_SPEED_FINE:     steer_cfg.speed_fine = value[14:0];
			CFG_SPEED_STRONG:   steer_cfg.speed_strong = value[14:0];
			CFG_SPEED_SEARCH:   steer_cfg.speed_search = value[14:0];
			CFG_STEER_FINE:     steer_cfg.steer_fine = value[14:0];
			CFG_STEER_STRONG:   steer_cfg.steer_strong = value[14:0];
			CFG_STEER_SEARCH:   steer_cfg.steer_search = value[14:0];
			default: ;
		endcase
	endtask

	task automatic restore_defaults();
		write_register(CFG_GYRO_BIAS, GYRO_BIAS_RST);
		write_register(CFG_SPEED_STRAIGHT, {1'b0, SPEED_STRAIGHT_RST});
		write_register(CFG_SPEED_FINE, {1'b0, SPEED_FINE_RST});
		write_register(CFG_SPEED_STRONG, {1'b0, SPEED_STRONG_RST});
		write_register(CFG_SPEED_SEARCH, {1'b0, SPEED_SEARCH_RST});
		write_register(CFG_STEER_FINE, {1'b0, STEER_FINE_RST});
		write_register(CFG_STEER_STRONG, {1'b0, STEER_STRONG_RST});
		write_register(CFG_STEER_SEARCH, {1'b0, STEER_SEARCH_RST});
	endtask

	// Every mode, with a selection of score patterns, under the reset register values.
	task automatic test_decision_modes();
		send_sample(make_sensors(1, 1, 1, 0, 1, 1, 1), 16'sd100);
		send_sample(make_sensors(0, 0, 0, 0, 0, 1, 0), 16'sd0);
		send_sample(make_sensors(1, 0, 1, 0, 0, 0, 0), 16'sd0);
		send_sample(make_sensors(1, 1, 0, 0, 0, 0, 0), 16'sd300);
		send_sample(make_sensors(0, 1, 0, 0, 0, 0, 0), -16'sd40);
		send_sample(make_sensors(0, 0, 1, 1, 1, 0, 0), 16'sd0);
		send_sample(make_sensors(0, 0, 0, 0, 1, 0, 0), -16'sd300);
		send_sample(make_sensors(0, 0, 0, 1, 0, 0, 0), 16'sd55);
		send_sample(make_sensors(0, 0, 0, 0, 0, 0, 1), 16'sd0);
		send_sample(make_sensors(0, 1, 1, 1, 0, 0, 0), 16'sd0);
		send_sample(make_sensors(0, 0, 0, 0, 0, 0, 0), 16'sd0);
		send_sample(make_sensors(1, 1, 0, 0, 1, 0, 0), 16'sd0);
		send_sample(make_sensors(1, 1, 1, 1, 1, 0, 0), 16'sd0);
		drain_pipeline();
	endtask

	// Damping around its steps and cap, and saturation of the corrected rate.
	task automatic test_gyro_damping();
		send_sample(make_sensors(0, 1, 0, 0, 0, 0, 0), 16'sd1);
		send_sample(make_sensors(0, 1, 0, 0, 0, 0, 0), 16'sd20);
		send_sample(make_sensors(0, 0, 0, 1, 0, 0, 0), 16'sd1251);
		send_sample(make_sensors(1, 0, 0, 0, 0, 0, 0), 16'sh7FFF);
		send_sample(make_sensors(0, 0, 1, 0, 1, 0, 0), 16'sh8000);
		drain_pipeline();
		write_register(CFG_GYRO_BIAS, 16'h7FFF);
		send_sample(make_sensors(0, 1, 0, 0, 0, 0, 0), 16'sh8000);
		send_sample(make_sensors(0, 0, 0, 1, 0, 0, 0), 16'sh7FFF);
		drain_pipeline();
		write_register(CFG_GYRO_BIAS, 16'h8000);
		send_sample(make_sensors(1, 0, 1, 0, 0, 0, 0), 16'sh7FFF);
		send_sample(make_sensors(0, 0, 0, 1, 0, 0, 0), 16'sh8000);
		drain_pipeline();
		write_register(CFG_GYRO_BIAS, GYRO_BIAS_RST);
	endtask

	// Zero steer strength, and floors that lie above their caps.
	task automatic test_special_cases();
		write_register(CFG_STEER_FINE, 16'd0);
		write_register(CFG_STEER_STRONG, 16'd0);
		send_sample(make_sensors(0, 1, 0, 0, 0, 0, 0), 16'sd2000);
		send_sample(make_sensors(0, 0, 1, 1, 1, 0, 0), -16'sd2000);
		drain_pipeline();
		write_register(CFG_STEER_FINE, 16'd100);
		write_register(CFG_STEER_STRONG, 16'd2000);
		write_register(CFG_STEER_SEARCH, 16'd300);
		send_sample(make_sensors(0, 0, 0, 1, 0, 0, 0), 16'sd0);
		send_sample(make_sensors(1, 0, 1, 0, 0, 0, 0), 16'sd0);
		send_sample(make_sensors(0, 0, 0, 0, 1, 0, 0), 16'sd900);
		drain_pipeline();
		// Fine speed and search steer at the top, straight speed at zero so the inner clamp crosses.
		write_register(CFG_SPEED_STRAIGHT, 16'd0);
		write_register(CFG_SPEED_FINE, 16'h7FFF);
		write_register(CFG_STEER_SEARCH, 16'h7FFF);
		send_sample(make_sensors(0, 1, 0, 0, 0, 0, 0), 16'sd0);
		send_sample(make_sensors(0, 0, 0, 0, 1, 0, 0), 16'sd0);
		drain_pipeline();
		restore_defaults();
	endtask

	function automatic logic [15:0] random_speed();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h7FFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 12000));
		endcase
	endfunction

	function automatic logic [15:0] random_bias();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			1: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	// Several random register settings, each followed by random samples.
	task automatic test_random_settings();
		repeat (6) begin
			write_register(CFG_GYRO_BIAS, random_bias());
			write_register(CFG_SPEED_STRAIGHT, random_speed());
			write_register(CFG_SPEED_FINE, random_speed());
			write_register(CFG_SPEED_STRONG, random_speed());
			write_register(CFG_SPEED_SEARCH, random_speed());
			write_register(CFG_STEER_FINE, random_speed());
			write_register(CFG_STEER_STRONG, random_speed());
			write_register(CFG_STEER_SEARCH, random_speed());
			tx_idle_en = $urandom_range(0, 3) != 0;
			rx_idle_en = $urandom_range(0, 3) != 0;
			send_random_samples(150);
			drain_pipeline();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		restore_defaults();
	endtask

	// The receiver holds off for a long stretch while samples keep coming.
	task automatic test_output_backpressure();
		hold_len = 300;
		hold_req = 1'b1;
		tx_idle_en = 1'b0;
		send_random_samples(80);
		tx_idle_en = 1'b1;
		drain_pipeline();
	endtask

	// The sender stops until the pipeline is empty, then resumes.
	task automatic test_sender_pause();
		send_random_samples(30);
		drain_pipeline();
		send_random_samples(30);
		drain_pipeline();
	endtask

	// Back-to-back transactions with no idling on either side.
	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_random_samples(200);
		drain_pipeline();
	endtask

	initial begin
		steer_cfg.gyro_bias = GYRO_BIAS_RST;
		steer_cfg.speed_straight = SPEED_STRAIGHT_RST;
		steer_cfg.speed_fine = SPEED_FINE_RST;
		steer_cfg.speed_strong = SPEED_STRONG_RST;
		steer_cfg.speed_search = SPEED_SEARCH_RST;
		steer_cfg.steer_fine = STEER_FINE_RST;
		steer_cfg.steer_strong = STEER_STRONG_RST;
		steer_cfg.steer_search = STEER_SEARCH_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_decision_modes();
		test_gyro_damping();
		test_special_cases();
		test_random_settings();
		test_output_backpressure();
		test_sender_pause();
		test_full_rate();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
